// ===== rtl/core/wcc_pkg.sv =====
// ----------------------------------------------------------------------------
// wcc_pkg
// Shared types, constants and elaboration-time table builders for the
// wind chill comparison core (old-style and new-style index).
// ----------------------------------------------------------------------------
package wcc_pkg;

    // default configuration
    localparam int FRAC_BITS_DEF  = 4;
    localparam int WIND_TABLE_DEF = 256;

    // field widths
    localparam int TEMP_W  = 12;
    localparam int WIND_W  = 8;
    localparam int CHILL_W = 16;
    localparam int DIFF_W  = 15;

    // output limits
    localparam int CHILL_MAX = 32767;
    localparam int CHILL_MIN = -32768;
    localparam int DIFF_MAX  = 32767;

    // table geometry
    localparam int ROM_ENTRIES = 256;
    localparam int ROM_Q       = 14;
    localparam int ROM_GW      = 26;   // 81 * w, unsigned
    localparam int ROM_BW      = 34;   // new-index constant term, signed
    localparam int ROM_HW      = 27;   // new-index temperature slope, unsigned
    localparam int POW_STEPS   = 24;

    // old index: 81*w*(5*t - 457*2^f) / (2^17 * 625)
    localparam int OLD_T_OFS   = 457;
    localparam int OLD_BIAS    = 914;  // 91.4 in tenths
    localparam int OLD_SHIFT   = 17;
    localparam int OLD_DIV     = 625;
    localparam int OLD_DIV_LOG = 9;    // 2^9 <= 625
    localparam int OLD_REM_W   = 11;   // remainder below 2*625

    // new index: (b*2^f + t*h) / (2^18 * 125)
    localparam int NEW_SHIFT   = 18;
    localparam int NEW_DIV     = 125;
    localparam int NEW_DIV_LOG = 6;    // 2^6 <= 125
    localparam int NEW_REM_W   = 8;    // remainder below 2*125

    localparam int PIPE_STAGES = 8;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_f_q4;
        logic        [WIND_W-1:0] wind_mph;
    } t_wcc_in;

    typedef struct packed {
        logic signed [CHILL_W-1:0] old_chill_q4;
        logic signed [CHILL_W-1:0] new_chill_q4;
        logic        [DIFF_W-1:0]  chill_diff_q4;
    } t_wcc_out;

    // per wind speed coefficients
    typedef struct packed {
        logic        [ROM_GW-1:0] g;
        logic signed [ROM_BW-1:0] b;
        logic        [ROM_HW-1:0] h;
    } t_rom_ent;

    // true when the 25-fold q14 self product of x passes tgt
    function automatic logic pow25_exceeds(input longint unsigned x,
                                           input longint unsigned tgt);
        longint unsigned acc;
        logic            over;
        acc  = x;
        over = (acc > tgt);
        for (int k = 0; k < POW_STEPS; k++) begin
            if (!over) begin
                acc  = (acc * x) >> ROM_Q;
                over = (acc > tgt);
            end
        end
        return over;
    endfunction

    // coefficients for one wind speed, built at elaboration
    function automatic t_rom_ent rom_entry(input int v);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        longint unsigned tgt;
        longint          sq;
        longint          pw;
        longint          num;
        longint          w;
        t_rom_ent        ent;
        // floor(sqrt(v) * 2^14) by bisection
        tgt = 64'(v) << 28;
        lo  = 0;
        hi  = 64'd1 << 19;
        for (int i = 0; i < 20; i++) begin
            if (hi - lo > 1) begin
                mid = (lo + hi) >> 1;
                if (mid * mid <= tgt) lo = mid;
                else hi = mid;
            end
        end
        sq = longint'(lo);
        // v^0.16 in q14: largest x whose 25th power does not exceed v^4
        if (v == 0) begin
            pw = 0;
        end else begin
            tgt = (64'(v) * 64'(v) * 64'(v) * 64'(v)) << ROM_Q;
            lo  = 64'd1 << ROM_Q;
            hi  = 64'd1 << 16;
            for (int i = 0; i < 17; i++) begin
                if (hi - lo > 1) begin
                    mid = (lo + hi) >> 1;
                    if (!pow25_exceeds(mid, tgt)) lo = mid;
                    else hi = mid;
                end
            end
            pw = longint'(lo);
        end
        // wind factor in q14, rounded half away from zero
        num = 64'sd37100 * sq + (64'sd58100 - 64'sd2500 * longint'(v)) * 64'sd16384;
        if (num >= 0) w = (num + 5000) / 10000;
        else w = -((-num + 5000) / 10000);
        ent.g = ROM_GW'(64'sd81 * w);
        ent.b = ROM_BW'(64'sd71480 * 64'sd16384 - 64'sd71500 * pw);
        ent.h = ROM_HW'(64'sd1243 * 64'sd16384 + 64'sd855 * pw);
        return ent;
    endfunction

endpackage

// ===== rtl/core/wind_chill_old_new_compare_core.sv =====
// ----------------------------------------------------------------------------
// wind_chill_old_new_compare_core
// Pipelined wind chill calculator: old-style index, new-style index and
// their absolute difference, fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
//  channel   direction  transfer                 payload
//  command   in         start high, busy low     i_item   (t_wcc_in)
//  result    out        o_valid high, 1 cycle    o_result (t_wcc_out)
//
//  one item per clock cycle, busy stays low
//  between the start transfer and o_valid the item passes through the
//  coefficient table read, the two multiplier levels and the constant
//  divider correction steps
//  synchronous reset clears the valid pipe, payload registers are not reset
//  the receiver takes every result in its strobe cycle; nothing stalls
// ----------------------------------------------------------------------------
module wind_chill_old_new_compare_core #(
    parameter int FRAC_BITS       = wcc_pkg::FRAC_BITS_DEF,
    parameter int WIND_TABLE_SIZE = wcc_pkg::WIND_TABLE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  wcc_pkg::t_wcc_in  i_item,
    output logic              o_valid,
    output wcc_pkg::t_wcc_out o_result
);

    // table geometry
    localparam int ROM_DEPTH = (WIND_TABLE_SIZE < wcc_pkg::ROM_ENTRIES) ?
                               WIND_TABLE_SIZE : wcc_pkg::ROM_ENTRIES;
    localparam int IW        = $clog2(ROM_DEPTH);
    localparam logic [wcc_pkg::WIND_W:0] LAST_W = (wcc_pkg::WIND_W+1)'(ROM_DEPTH - 1);

    // datapath widths
    localparam int TW    = wcc_pkg::TEMP_W;
    localparam int EW    = FRAC_BITS + 16;
    localparam int XOW   = wcc_pkg::ROM_GW + 1 + EW;
    localparam int YOW   = XOW - wcc_pkg::OLD_SHIFT;
    localparam int QOW   = YOW - wcc_pkg::OLD_DIV_LOG;
    localparam int PNW   = TW + wcc_pkg::ROM_HW + 1;
    localparam int BSW   = wcc_pkg::ROM_BW + FRAC_BITS;
    localparam int XNW   = ((BSW > PNW) ? BSW : PNW) + 1;
    localparam int YNW   = XNW - wcc_pkg::NEW_SHIFT;
    localparam int QNW   = YNW - wcc_pkg::NEW_DIV_LOG;
    localparam int VW    = ((QOW > QNW) ? QOW : QNW) + 2;
    localparam int DW    = VW + 1;
    localparam int OREMW = wcc_pkg::OLD_REM_W;
    localparam int NREMW = wcc_pkg::NEW_REM_W;
    localparam int NSTG  = wcc_pkg::PIPE_STAGES;
    localparam int CW    = wcc_pkg::CHILL_W;
    localparam int FW    = wcc_pkg::DIFF_W;

    // constants
    localparam logic signed [EW-1:0] E_OFS =
        EW'(wcc_pkg::OLD_T_OFS) <<< FRAC_BITS;
    localparam logic [XOW-1:0] HALF_O =
        XOW'((64'd1 << (wcc_pkg::OLD_SHIFT - 1)) * 64'(wcc_pkg::OLD_DIV));
    localparam logic [XNW-1:0] HALF_N =
        XNW'((64'd1 << (wcc_pkg::NEW_SHIFT - 1)) * 64'(wcc_pkg::NEW_DIV));
    localparam logic [QOW-1:0] RECIP_O = QOW'((64'd1 << YOW) / 64'(wcc_pkg::OLD_DIV));
    localparam logic [QNW-1:0] RECIP_N = QNW'((64'd1 << YNW) / 64'(wcc_pkg::NEW_DIV));
    localparam logic signed [VW-1:0] C_OLD =
        VW'((wcc_pkg::OLD_BIAS * (1 << FRAC_BITS) + 5) / 10);
    localparam logic signed [VW-1:0] SAT_HI  = VW'(wcc_pkg::CHILL_MAX);
    localparam logic signed [VW-1:0] SAT_LO  = VW'(wcc_pkg::CHILL_MIN);
    localparam logic signed [DW-1:0] DIFF_HI = DW'(wcc_pkg::DIFF_MAX);

    // coefficient table, one entry per wind speed
    wcc_pkg::t_rom_ent rom [ROM_DEPTH];

    for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
        localparam wcc_pkg::t_rom_ent ENT = wcc_pkg::rom_entry(gi);
        assign rom[gi] = ENT;
    end

    logic [NSTG-1:0] r_vld;

    logic [wcc_pkg::WIND_W-1:0] n1_wind;
    logic [IW-1:0]              n1_idx;
    logic signed [TW-1:0]       r1_t;
    wcc_pkg::t_rom_ent          r1_ent;

    logic signed [EW-1:0]  n2_e;
    logic signed [XOW-1:0] r2_xo;
    logic signed [PNW-1:0] r2_pn;
    logic signed [BSW-1:0] r2_bs;

    logic [XOW-1:0]        n3_mo;
    logic [YOW-1:0]        r3_yo;
    logic                  r3_so;
    logic signed [XNW-1:0] r3_xn;

    logic [YOW+QOW-1:0] n4_po;
    logic [QOW-1:0]     r4_qo0;
    logic [YOW-1:0]     r4_yo;
    logic               r4_so;
    logic [XNW-1:0]     n4_mn;
    logic [YNW-1:0]     r4_yn;
    logic               r4_sn;

    logic [YOW-1:0]     n5_qmo;
    logic [YOW-1:0]     n5_ro;
    logic [OREMW-1:0]   r5_ro;
    logic [QOW-1:0]     r5_qo0;
    logic               r5_so;
    logic [YNW+QNW-1:0] n5_pn;
    logic [QNW-1:0]     r5_qn0;
    logic [YNW-1:0]     r5_yn;
    logic               r5_sn;

    logic [QOW-1:0]       n6_qo;
    logic signed [VW-1:0] r6_old;
    logic [YNW-1:0]       n6_qmn;
    logic [YNW-1:0]       n6_rn;
    logic [NREMW-1:0]     r6_rn;
    logic [QNW-1:0]       r6_qn0;
    logic                 r6_sn;

    logic [QNW-1:0]       n7_qn;
    logic signed [VW-1:0] r7_old;
    logic signed [VW-1:0] r7_new;

    logic signed [DW-1:0] n8_d;
    logic signed [DW-1:0] n8_ad;
    wcc_pkg::t_wcc_out    n8_res;
    wcc_pkg::t_wcc_out    r8_res;

    // no back pressure: a transfer can happen in every cycle
    assign busy = 1'b0;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], start & ~busy};
        end
    end

    // stage 1: clamp wind speed, table read
    always_comb begin
        n1_wind = ({1'b0, i_item.wind_mph} > LAST_W) ?
                  LAST_W[wcc_pkg::WIND_W-1:0] : i_item.wind_mph;
        n1_idx  = n1_wind[IW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r1_t   <= i_item.temp_f_q4;
        r1_ent <= rom[n1_idx];
    end

    // stage 2: products; 5*t is a shift and add
    assign n2_e = (EW'(r1_t) <<< 2) + EW'(r1_t) - E_OFS;

    always_ff @(posedge i_clk) begin
        r2_xo <= $signed({1'b0, r1_ent.g}) * n2_e;
        r2_pn <= r1_t * $signed({1'b0, r1_ent.h});
        r2_bs <= BSW'(r1_ent.b) <<< FRAC_BITS;
    end

    // stage 3: old magnitude plus half divisor, shift; new sum
    assign n3_mo = r2_xo[XOW-1] ? (HALF_O - $unsigned(r2_xo)) : ($unsigned(r2_xo) + HALF_O);

    always_ff @(posedge i_clk) begin
        r3_yo <= n3_mo[XOW-1:wcc_pkg::OLD_SHIFT];
        r3_so <= r2_xo[XOW-1];
        r3_xn <= XNW'(r2_bs) + XNW'(r2_pn);
    end

    // stage 4: old reciprocal product; new magnitude plus half, shift
    always_comb begin
        n4_po = YOW'(r3_yo) * (YOW+QOW)'(RECIP_O);
        n4_mn = r3_xn[XNW-1] ? (HALF_N - $unsigned(r3_xn)) : ($unsigned(r3_xn) + HALF_N);
    end

    always_ff @(posedge i_clk) begin
        r4_qo0 <= n4_po[YOW+QOW-1:YOW];
        r4_yo  <= r3_yo;
        r4_so  <= r3_so;
        r4_yn  <= n4_mn[XNW-1:wcc_pkg::NEW_SHIFT];
        r4_sn  <= r3_xn[XNW-1];
    end

    // stage 5: old remainder; new reciprocal product
    always_comb begin
        n5_qmo = YOW'(r4_qo0) * YOW'(wcc_pkg::OLD_DIV);
        n5_ro  = r4_yo - n5_qmo;
        n5_pn  = (YNW+QNW)'(r4_yn) * (YNW+QNW)'(RECIP_N);
    end

    always_ff @(posedge i_clk) begin
        r5_ro  <= n5_ro[OREMW-1:0];
        r5_qo0 <= r4_qo0;
        r5_so  <= r4_so;
        r5_qn0 <= n5_pn[YNW+QNW-1:YNW];
        r5_yn  <= r4_yn;
        r5_sn  <= r4_sn;
    end

    // stage 6: old quotient fix-up, sign and offset; new remainder
    always_comb begin
        n6_qo  = r5_qo0 + QOW'(r5_ro >= OREMW'(wcc_pkg::OLD_DIV));
        n6_qmn = YNW'(r5_qn0) * YNW'(wcc_pkg::NEW_DIV);
        n6_rn  = r5_yn - n6_qmn;
    end

    always_ff @(posedge i_clk) begin
        r6_old <= (r5_so ? -VW'(n6_qo) : VW'(n6_qo)) + C_OLD;
        r6_rn  <= n6_rn[NREMW-1:0];
        r6_qn0 <= r5_qn0;
        r6_sn  <= r5_sn;
    end

    // stage 7: new quotient fix-up and sign
    assign n7_qn = r6_qn0 + QNW'(r6_rn >= NREMW'(wcc_pkg::NEW_DIV));

    always_ff @(posedge i_clk) begin
        r7_old <= r6_old;
        r7_new <= r6_sn ? -VW'(n7_qn) : VW'(n7_qn);
    end

    // stage 8: difference and output saturation
    always_comb begin
        n8_d  = DW'(r7_old) - DW'(r7_new);
        n8_ad = n8_d[DW-1] ? -n8_d : n8_d;
        if (r7_old > SAT_HI) begin
            n8_res.old_chill_q4 = CW'(wcc_pkg::CHILL_MAX);
        end else if (r7_old < SAT_LO) begin
            n8_res.old_chill_q4 = CW'(wcc_pkg::CHILL_MIN);
        end else begin
            n8_res.old_chill_q4 = r7_old[CW-1:0];
        end
        if (r7_new > SAT_HI) begin
            n8_res.new_chill_q4 = CW'(wcc_pkg::CHILL_MAX);
        end else if (r7_new < SAT_LO) begin
            n8_res.new_chill_q4 = CW'(wcc_pkg::CHILL_MIN);
        end else begin
            n8_res.new_chill_q4 = r7_new[CW-1:0];
        end
        if (n8_ad > DIFF_HI) begin
            n8_res.chill_diff_q4 = FW'(wcc_pkg::DIFF_MAX);
        end else begin
            n8_res.chill_diff_q4 = n8_ad[FW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r8_res <= n8_res;
    end

    assign o_valid  = r_vld[NSTG-1];
    assign o_result = r8_res;

    // checks
    logic signed [CW:0] a_dd;
    logic signed [CW:0] a_ad;
    assign a_dd = (CW+1)'(o_result.old_chill_q4) - (CW+1)'(o_result.new_chill_q4);
    assign a_ad = a_dd[CW] ? -a_dd : a_dd;

    // every result traces back to a command transfer the depth of the valid pipe ago
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start, NSTG))
        else $error("result strobe without matching command transfer");

    // reciprocal estimate is at most one below the true quotient
    a_old_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[4] |-> (r5_ro < OREMW'(2 * wcc_pkg::OLD_DIV)))
        else $error("old index remainder out of range");

    a_new_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[5] |-> (r6_rn < NREMW'(2 * wcc_pkg::NEW_DIV)))
        else $error("new index remainder out of range");

    // unsaturated outputs agree with the reported difference
    a_diff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.chill_diff_q4 != FW'(wcc_pkg::DIFF_MAX)
         && o_result.old_chill_q4 != CW'(wcc_pkg::CHILL_MAX)
         && o_result.old_chill_q4 != CW'(wcc_pkg::CHILL_MIN)
         && o_result.new_chill_q4 != CW'(wcc_pkg::CHILL_MAX)
         && o_result.new_chill_q4 != CW'(wcc_pkg::CHILL_MIN))
        |-> (o_result.chill_diff_q4 == a_ad[FW-1:0]))
        else $error("difference does not match the two indexes");

endmodule
